[src/mtl_pkg.sv]
// ----------------------------------------------------------------------------
// mtl_pkg: shared types and constants for the multibit trie LPM lookup
// Item and configuration structs, opcodes, register indexes and route codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtl_pkg;

  // Defaults for the top-level parameters.
  localparam int NODE_COUNT_DEF = 256;
  localparam int HOP_WIDTH_DEF  = 32;

  // Fixed field widths.
  localparam int NODE_W    = 8;
  localparam int SLOT_W    = 8;
  localparam int ADDR_W    = 128;
  localparam int OUT_HOP_W = 32;
  localparam int LVL_W     = 4;
  localparam int Q_DEPTH   = 2;

  // Last walk level for each address family.
  localparam logic [LVL_W-1:0] LVL_LAST4 = 4'd3;
  localparam logic [LVL_W-1:0] LVL_LAST6 = 4'd15;

  // Item opcodes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Route source codes.
  localparam logic [1:0] SRC_NONE    = 2'd0;
  localparam logic [1:0] SRC_PREFIX  = 2'd1;
  localparam logic [1:0] SRC_DEFAULT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROOT    = 2'd0;
  localparam logic [1:0] REG_IPV6    = 2'd1;
  localparam logic [1:0] REG_DEF_EN  = 2'd2;
  localparam logic [1:0] REG_DEF_HOP = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0]    root;
    logic                 ipv6;
    logic                 def_en;
    logic [OUT_HOP_W-1:0] def_hop;
  } cfg_t;

  typedef struct packed {
    logic                 op;
    logic [ADDR_W-1:0]    addr;
    logic [NODE_W-1:0]    wr_node;
    logic [SLOT_W-1:0]    wr_slot;
    logic [NODE_W-1:0]    wr_child;
    logic                 wr_valid;
    logic [OUT_HOP_W-1:0] wr_hop;
    logic                 in_pool;
  } item_t;

  // Nodes actually held: node indexes are 8 bits wide.
  function automatic int nodes_held(input int node_count);
    return (node_count < 256) ? node_count : 256;
  endfunction

endpackage

`default_nettype wire

[src/mtl_front.sv]
// ----------------------------------------------------------------------------
// mtl_front: item intake and classification
// Accepts items, decodes the opcode, checks write nodes against the pool and
// trims next hops to the configured width before queueing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtl_front
  import mtl_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int HOP_WIDTH  = HOP_WIDTH_DEF
) (
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_func,
  input  wire logic [63:0]          in_addr_hi,
  input  wire logic [63:0]          in_addr_lo,
  input  wire logic [NODE_W-1:0]    in_wr_node,
  input  wire logic [SLOT_W-1:0]    in_wr_slot,
  input  wire logic [NODE_W-1:0]    in_wr_child,
  input  wire logic                 in_wr_valid,
  input  wire logic [OUT_HOP_W-1:0] in_wr_hop,
  input  wire logic                 clearing,
  input  wire logic                 q_full,
  output logic                      push,
  output item_t                     push_item
);

  localparam int NODES = nodes_held(NODE_COUNT);
  localparam logic [OUT_HOP_W-1:0] HOP_MASK = 32'hFFFF_FFFF >> (OUT_HOP_W - HOP_WIDTH);

  assign busy = clearing || q_full;
  assign push = start && !busy;

  always_comb begin
    push_item          = '0;
    push_item.op       = in_func ? OP_WRITE : OP_LOOKUP;
    push_item.addr     = {in_addr_hi, in_addr_lo};
    push_item.wr_node  = in_wr_node;
    push_item.wr_slot  = in_wr_slot;
    push_item.wr_child = in_wr_child;
    push_item.wr_valid = in_wr_valid;
    push_item.wr_hop   = in_wr_hop & HOP_MASK;
    // Writes to nodes outside the pool are dropped by the back end.
    push_item.in_pool  = ({1'b0, in_wr_node} < 9'(NODES));
  end

endmodule

`default_nettype wire

[src/mtl_queue.sv]
// ----------------------------------------------------------------------------
// mtl_queue: short item queue between front and back
// A small register FIFO so intake and the trie walk stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtl_queue
  import mtl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output item_t      head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t             slots_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[src/mtl_back.sv]
// ----------------------------------------------------------------------------
// mtl_back: entry store and trie walk engine
// Holds the trie entries in one memory, clears it after reset, applies
// entry writes and walks lookups one level per memory read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtl_back
  import mtl_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int HOP_WIDTH  = HOP_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_valid,
  input  wire item_t                q_item,
  output logic                      q_pop,
  output logic                      clearing,
  output logic                      out_valid,
  output logic [OUT_HOP_W-1:0]      out_next_hop,
  output logic [1:0]                out_route_source
);

  localparam int NODES = nodes_held(NODE_COUNT);
  localparam int NB    = $clog2(NODES);
  localparam int AW    = NB + SLOT_W;
  localparam int DEPTH = NODES * (2 ** SLOT_W);
  localparam int EW    = NODE_W + 1 + HOP_WIDTH;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  function automatic logic [AW-1:0] mk_addr(input logic [NODE_W-1:0] node,
                                            input logic [SLOT_W-1:0] slot);
    return {node[NB-1:0], slot};
  endfunction

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] mem_q_r;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_idx_r, clr_idx_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic                 node_ok_r, node_ok_nxt;
  logic [HOP_WIDTH-1:0] hop_r, hop_nxt;
  logic                 matched_r, matched_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_HOP_W-1:0] out_hop_r, out_hop_nxt;
  logic [1:0]           out_src_r, out_src_nxt;

  logic [EW-1:0]        ent;
  logic [NODE_W-1:0]    ent_child;
  logic                 ent_valid;
  logic [HOP_WIDTH-1:0] ent_hop;
  logic [HOP_WIDTH-1:0] hop_cur;
  logic                 matched_cur;
  logic                 walk_done;

  // An entry of a node outside the pool reads as all zero.
  assign ent         = node_ok_r ? mem_q_r : '0;
  assign ent_child   = ent[EW-1 -: NODE_W];
  assign ent_valid   = ent[HOP_WIDTH];
  assign ent_hop     = ent[HOP_WIDTH-1:0];
  assign hop_cur     = ent_valid ? ent_hop : hop_r;
  assign matched_cur = matched_r || ent_valid;
  assign walk_done   = (ent_child == '0) ||
                       (lvl_r == (cfg.ipv6 ? LVL_LAST6 : LVL_LAST4));

  assign clearing         = (state_r == ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_next_hop     = out_hop_r;
  assign out_route_source = out_src_r;

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    q_pop         = 1'b0;
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    addr_nxt      = addr_r;
    lvl_nxt       = lvl_r;
    node_ok_nxt   = node_ok_r;
    hop_nxt       = hop_r;
    matched_nxt   = matched_r;
    out_valid_nxt = 1'b0;
    out_hop_nxt   = out_hop_r;
    out_src_nxt   = out_src_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_WRITE) begin
            wr_en   = q_item.in_pool;
            wr_addr = mk_addr(q_item.wr_node, q_item.wr_slot);
            wr_data = {q_item.wr_child, q_item.wr_valid, q_item.wr_hop[HOP_WIDTH-1:0]};
          end else begin
            rd_en       = 1'b1;
            rd_addr     = mk_addr(cfg.root, q_item.addr[ADDR_W-1 -: SLOT_W]);
            addr_nxt    = q_item.addr << SLOT_W;
            lvl_nxt     = '0;
            node_ok_nxt = ({1'b0, cfg.root} < 9'(NODES));
            hop_nxt     = '0;
            matched_nxt = 1'b0;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (matched_cur) begin
            out_hop_nxt = OUT_HOP_W'(hop_cur);
            out_src_nxt = SRC_PREFIX;
          end else if (cfg.def_en) begin
            out_hop_nxt = OUT_HOP_W'(cfg.def_hop[HOP_WIDTH-1:0]);
            out_src_nxt = SRC_DEFAULT;
          end else begin
            out_hop_nxt = '0;
            out_src_nxt = SRC_NONE;
          end
        end else begin
          rd_en       = 1'b1;
          rd_addr     = mk_addr(ent_child, addr_r[ADDR_W-1 -: SLOT_W]);
          addr_nxt    = addr_r << SLOT_W;
          lvl_nxt     = lvl_r + 1'b1;
          node_ok_nxt = ({1'b0, ent_child} < 9'(NODES));
          hop_nxt     = hop_cur;
          matched_nxt = matched_cur;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    lvl_r     <= lvl_nxt;
    node_ok_r <= node_ok_nxt;
    hop_r     <= hop_nxt;
    matched_r <= matched_nxt;
    out_hop_r <= out_hop_nxt;
    out_src_r <= out_src_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/multibit_trie_lpm_lookup.sv]
// ----------------------------------------------------------------------------
// multibit_trie_lpm_lookup: longest-prefix-match lookup over a stride-8 trie
// Entry writes and address lookups share one item channel; results come
// out as single-cycle strobes. Configuration sits behind an APB-style port.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  --------------------------------
//  input     start & !busy                   in_func, in_addr_hi/lo, in_wr_*
//  result    out_valid (one cycle, no stall) out_next_hop, out_route_source
//  config    psel & penable & pwrite         paddr[3:2] selects, pwdata
//
// After reset the entry store is cleared one entry per cycle, all NODES * 256
// entries (65536 with the default pool), with busy high. The engine applies a
// write as it pops it; a lookup visits one to four levels in IPv4 mode and one
// to 16 in IPv6, each level one read of the entry memory. The result strobe is
// registered from the last walk step. busy rises when the two-item queue is
// full; results cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multibit_trie_lpm_lookup
  import mtl_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int HOP_WIDTH  = HOP_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  // Item channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_func,
  input  wire logic [63:0]          in_addr_hi,
  input  wire logic [63:0]          in_addr_lo,
  input  wire logic [NODE_W-1:0]    in_wr_node,
  input  wire logic [SLOT_W-1:0]    in_wr_slot,
  input  wire logic [NODE_W-1:0]    in_wr_child,
  input  wire logic                 in_wr_valid,
  input  wire logic [OUT_HOP_W-1:0] in_wr_hop,

  // Result channel
  output logic                      out_valid,
  output logic [OUT_HOP_W-1:0]      out_next_hop,
  output logic [1:0]                out_route_source,

  // Configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Configuration registers. The user must change them only while the block is idle;
  // the block itself does not enforce this, and the walk engine reads them directly.
  logic [NODE_W-1:0]    root_r;
  logic                 ipv6_r;
  logic                 def_en_r;
  logic [OUT_HOP_W-1:0] def_hop_r;
  logic [1:0]           reg_idx;
  logic                 cfg_wr;
  cfg_t                 cfg;

  logic  clearing;
  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r    <= NODE_W'(1);
      ipv6_r    <= 1'b0;
      def_en_r  <= 1'b0;
      def_hop_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROOT:    root_r    <= pwdata[NODE_W-1:0];
        REG_IPV6:    ipv6_r    <= pwdata[0];
        REG_DEF_EN:  def_en_r  <= pwdata[0];
        REG_DEF_HOP: def_hop_r <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROOT:    prdata = {24'd0, root_r};
      REG_IPV6:    prdata = {31'd0, ipv6_r};
      REG_DEF_EN:  prdata = {31'd0, def_en_r};
      REG_DEF_HOP: prdata = def_hop_r;
    endcase
  end

  always_comb begin
    cfg.root    = root_r;
    cfg.ipv6    = ipv6_r;
    cfg.def_en  = def_en_r;
    cfg.def_hop = def_hop_r;
  end

  // Intake: accepts items and tags them for the walk engine.
  mtl_front #(
    .NODE_COUNT (NODE_COUNT),
    .HOP_WIDTH  (HOP_WIDTH)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_addr_hi  (in_addr_hi),
    .in_addr_lo  (in_addr_lo),
    .in_wr_node  (in_wr_node),
    .in_wr_slot  (in_wr_slot),
    .in_wr_child (in_wr_child),
    .in_wr_valid (in_wr_valid),
    .in_wr_hop   (in_wr_hop),
    .clearing    (clearing),
    .q_full      (q_full),
    .push        (q_push),
    .push_item   (q_push_item)
  );

  // Decoupling queue between intake and the walk engine.
  mtl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Walk engine with the entry store.
  mtl_back #(
    .NODE_COUNT (NODE_COUNT),
    .HOP_WIDTH  (HOP_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_head),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_next_hop     (out_next_hop),
    .out_route_source (out_route_source)
  );

endmodule

`default_nettype wire
